### hw/rtl/lpr_pkg.sv
// Shared types, constants and CRC step function for the length-prefixed packet receiver.
package lpr_pkg;

  localparam int unsigned COUNT_W = 11;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned STAT_W  = 2;

  localparam logic [CRC_W-1:0]   CRC_INIT    = 16'hFFFF;
  localparam logic [CRC_W-1:0]   CRC_POLY    = 16'h1021;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd2000;
  localparam logic [COUNT_W-1:0] MIN_LENGTH  = 11'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_CRC_ERR  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] register_value;
  } lpr_result_t;

  // One byte through CRC-16 CCITT, MSB first, eight unrolled shift steps.
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/lpr_in_reg.sv
// Input register: holds one received byte until the framer consumes it.
module lpr_in_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [lpr_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                      in_stall,
  input  logic                      take,
  output logic                      item_valid,
  output logic [lpr_pkg::BYTE_W-1:0] item_byte
);
  import lpr_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              accept;

  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

  assign item_valid = valid_r;
  assign item_byte  = byte_r;

endmodule

### hw/rtl/lpr_frame.sv
// Packet framer: byte count, length, second byte, running CRC and the verdict logic.
module lpr_frame (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lpr_pkg::COUNT_W-1:0] cfg_wr_data,
  input  logic                        item_valid,
  input  logic [lpr_pkg::BYTE_W-1:0]  item_byte,
  input  logic                        out_free,
  output logic                        take,
  output logic                        res_load,
  output lpr_pkg::lpr_result_t        res
);
  import lpr_pkg::*;

  logic [COUNT_W-1:0] limit_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [CRC_W-1:0]   crc_r, crc_nxt;
  logic [BYTE_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0]  sec_r, sec_nxt;

  logic [COUNT_W-1:0] next_count;
  logic [BYTE_W-1:0]  len_eff, sec_eff;
  logic               ovf, done, ends;

  assign next_count = count_r + 1'b1;
  assign len_eff    = (count_r == '0) ? item_byte : len_r;
  assign sec_eff    = (count_r == COUNT_W'(1)) ? item_byte : sec_r;

  assign ovf  = next_count >= limit_r;
  assign done = !ovf && (next_count >= MIN_LENGTH)
                && (next_count == {{(COUNT_W-BYTE_W){1'b0}}, len_eff});
  assign ends = ovf || done;

  // Bytes that end a packet need the result register; others pass freely.
  assign take     = item_valid && (!ends || out_free);
  assign res_load = take && ends;

  always_comb begin
    res.status         = ST_OVERFLOW;
    res.register_value = '0;
    if (!ovf) begin
      if (item_byte == crc_r[BYTE_W-1:0]) begin
        res.status         = ST_OK;
        res.register_value = sec_eff;
      end else begin
        res.status = ST_CRC_ERR;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    len_nxt   = len_r;
    sec_nxt   = sec_r;
    if (take) begin
      if (ends) begin
        count_nxt = '0;
        crc_nxt   = CRC_INIT;
        len_nxt   = '0;
        sec_nxt   = '0;
      end else begin
        count_nxt = next_count;
        crc_nxt   = crc_feed(crc_r, item_byte);
        len_nxt   = len_eff;
        sec_nxt   = sec_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      count_r <= '0;
      crc_r   <= CRC_INIT;
      len_r   <= '0;
      sec_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      len_r   <= len_nxt;
      sec_r   <= sec_nxt;
    end
  end

endmodule

### hw/rtl/lpr_out_reg.sv
// Result register: holds one verdict until the downstream side takes it.
module lpr_out_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         res_load,
  input  lpr_pkg::lpr_result_t         res,
  output logic                         out_free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lpr_pkg::STAT_W-1:0]   out_status,
  output logic [lpr_pkg::BYTE_W-1:0]   out_register_value
);
  import lpr_pkg::*;

  logic        valid_r, valid_nxt;
  lpr_result_t res_r;

  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = res_r.status;
  assign out_register_value = res_r.register_value;

endmodule

### hw/rtl/length_prefixed_packet_receiver.sv
// A byte that ends a packet moves from the input register into the result register, which shows its verdict.
// Throughput: one byte per cycle while the result register is free; CRC is eight unrolled combinational steps.
// The input register refills in the cycle it drains, so bytes stream back to back.
// Reset (rst_n low, synchronous): clear count, length and second byte, load CRC 0xFFFF,
// load overflow limit 2000, and empty the input and result registers.
module length_prefixed_packet_receiver (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration: overflow limit
  input  logic                        cfg_wr_en,
  input  logic [lpr_pkg::COUNT_W-1:0] cfg_wr_data,
  // Received byte transactions
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lpr_pkg::BYTE_W-1:0]  in_rx_byte,
  // Verdict transactions
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lpr_pkg::STAT_W-1:0]  out_status,
  output logic [lpr_pkg::BYTE_W-1:0]  out_register_value
);
  import lpr_pkg::*;

  logic              take;
  logic              item_valid;
  logic [BYTE_W-1:0] item_byte;
  logic              out_free;
  logic              res_load;
  lpr_result_t       res;

  // Hold the incoming byte; release it when the framer advances.
  lpr_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .take       (take),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  // Advance the packet state; a byte that ends a packet waits only if
  // the result register is still full and downstream stalls.
  lpr_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item_byte   (item_byte),
    .out_free    (out_free),
    .take        (take),
    .res_load    (res_load),
    .res         (res)
  );

  // Hold the verdict until downstream drops stall.
  lpr_out_reg u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_load           (res_load),
    .res                (res),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_register_value (out_register_value)
  );

endmodule

### test/testbench.sv
// Self-checking testbench for the length-prefixed packet receiver with CRC-16 check.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpr_pkg::*;

  // A result may still be in flight this long after the last one came back.
  localparam int SETTLE_CYCLES  = 8;
  // Cycles without any transaction on either side before the run is called hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the deliberate receiver hold-off used to back up the block.
  localparam int HOLDOFF_CYCLES = 300;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic [1:0] {
    ROW_BYTE,      // send the byte in the value column
    ROW_GOOD_END,  // send the correct check byte for the packet so far
    ROW_BAD_END,   // send the inverted check byte
    ROW_LIMIT      // drain, then write the overflow limit
  } row_kind_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SNK,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [COUNT_W-1:0] value;
    bit                typed;   // expected verdict is given in the row itself
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] regval;
  } stim_row_t;

  // Directed opening: minimal and short packets, good and bad check bytes,
  // length headers of zero and one, a length equal to the limit, a packet
  // finishing just under the limit, and the limit extremes.
  localparam stim_row_t DIRECTED_ROWS [26] = '{
    '{ROW_BYTE,     11'd2,    1'b0, ST_OK,       8'd0},  // shortest legal packet
    '{ROW_GOOD_END, 11'd0,    1'b0, ST_OK,       8'd0},
    '{ROW_BYTE,     11'd3,    1'b0, ST_OK,       8'd0},
    '{ROW_BYTE,     11'hFF,   1'b0, ST_OK,       8'd0},
    '{ROW_BAD_END,  11'd0,    1'b1, ST_CRC_ERR,  8'd0},  // mismatch clears register value
    '{ROW_BYTE,     11'd4,    1'b0, ST_OK,       8'd0},
    '{ROW_BYTE,     11'h00,   1'b0, ST_OK,       8'd0},
    '{ROW_BYTE,     11'h80,   1'b0, ST_OK,       8'd0},
    '{ROW_GOOD_END, 11'd0,    1'b0, ST_OK,       8'd0},
    '{ROW_LIMIT,    11'd3,    1'b0, ST_OK,       8'd0},
    '{ROW_BYTE,     11'd0,    1'b0, ST_OK,       8'd0},  // zero length never completes
    '{ROW_BYTE,     11'hA5,   1'b0, ST_OK,       8'd0},
    '{ROW_BYTE,     11'h5A,   1'b1, ST_OVERFLOW, 8'd0},
    '{ROW_BYTE,     11'd1,    1'b0, ST_OK,       8'd0},  // length one never completes
    '{ROW_BYTE,     11'h01,   1'b0, ST_OK,       8'd0},
    '{ROW_BYTE,     11'hFE,   1'b1, ST_OVERFLOW, 8'd0},
    '{ROW_BYTE,     11'd3,    1'b0, ST_OK,       8'd0},  // length equals the limit
    '{ROW_BYTE,     11'h7F,   1'b0, ST_OK,       8'd0},
    '{ROW_BYTE,     11'h00,   1'b1, ST_OVERFLOW, 8'd0},  // overflow wins over completion
    '{ROW_BYTE,     11'd2,    1'b0, ST_OK,       8'd0},  // completes one under the limit
    '{ROW_GOOD_END, 11'd0,    1'b0, ST_OK,       8'd0},
    '{ROW_LIMIT,    11'd1,    1'b0, ST_OK,       8'd0},
    '{ROW_BYTE,     11'hFF,   1'b1, ST_OVERFLOW, 8'd0},  // limit below two: every byte overflows
    '{ROW_LIMIT,    11'd0,    1'b0, ST_OK,       8'd0},
    '{ROW_BYTE,     11'h00,   1'b1, ST_OVERFLOW, 8'd0},
    '{ROW_LIMIT,    11'd2047, 1'b0, ST_OK,       8'd0}
  };

  logic                clk                = 1'b0;
  logic                rst_n              = 1'b0;
  logic                cfg_wr_en          = 1'b0;
  logic [COUNT_W-1:0]  cfg_wr_data        = '0;
  logic                in_valid           = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_rx_byte         = '0;
  logic                out_valid;
  logic                out_stall          = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [BYTE_W-1:0]   out_register_value;

  // Receiver-side state of the predictor: mirrors what the block should hold.
  logic [COUNT_W-1:0]  rx_count;
  logic [CRC_W-1:0]    crc_acc;
  logic [BYTE_W-1:0]   hdr_len;
  logic [BYTE_W-1:0]   reg_byte;
  logic [COUNT_W-1:0]  ovf_limit;

  lpr_result_t         pending_verdicts [$];
  int                  verdict_errors     = 0;
  int                  bytes_sent         = 0;
  int                  quiet_cycles       = 0;
  int                  hold_left          = 0;
  bit                  start_holdoff      = 1'b0;
  idle_mode_t          traffic_mode       = IDLE_NONE;

  length_prefixed_packet_receiver u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_register_value (out_register_value)
  );

  always begin
    #4ns clk = 1'b1;
    #4ns clk = 1'b0;
  end

  // CRC-16 CCITT, one data bit per step: feedback is the top CRC bit xor the data bit.
  function automatic logic [CRC_W-1:0] crc16_ccitt_byte(input logic [CRC_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ b[i];
      c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return c;
  endfunction

  function automatic void clear_frame();
    rx_count = '0;
    crc_acc  = 16'hFFFF;
    hdr_len  = '0;
    reg_byte = '0;
  endfunction

  // Advance the receiver by one byte; return 1 and the verdict when the byte ends a packet.
  function automatic bit frame_step(input logic [BYTE_W-1:0] b, output lpr_result_t verdict);
    logic [COUNT_W-1:0] nxt;
    nxt     = rx_count + 1'b1;
    verdict = '0;
    if (rx_count == 0) begin
      hdr_len = b;
    end else if (rx_count == 1) begin
      reg_byte = b;
    end
    // Overflow is judged first, so it wins when the count also matches the length.
    if (nxt >= ovf_limit) begin
      verdict.status = ST_OVERFLOW;
      clear_frame();
      return 1'b1;
    end
    if (nxt >= MIN_LENGTH && nxt == {3'b000, hdr_len}) begin
      if (b == crc_acc[7:0]) begin
        verdict.status         = ST_OK;
        verdict.register_value = reg_byte;
      end else begin
        verdict.status = ST_CRC_ERR;
      end
      clear_frame();
      return 1'b1;
    end
    crc_acc  = crc16_ccitt_byte(crc_acc, b);
    rx_count = nxt;
    return 1'b0;
  endfunction

  function automatic int src_idle_pct(input idle_mode_t m);
    return (m == IDLE_SRC) ? 78 : (m == IDLE_BOTH) ? 23 : 0;
  endfunction

  function automatic int snk_stall_pct(input idle_mode_t m);
    return (m == IDLE_SNK) ? 78 : (m == IDLE_BOTH) ? 23 : 0;
  endfunction

  // Offer one byte and hold it until the block takes it. Entered and left just
  // after a rising edge, so in_valid sees exactly one assignment per edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < src_idle_pct(traffic_mode)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  // Drop valid and hold until every queued verdict has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the overflow limit while the block is quiet.
  task automatic set_limit(input logic [COUNT_W-1:0] limit);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    ovf_limit    = limit;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Send one packet from header to verdict. Most packets are short and
  // well formed; noisy ones carry any header (zero and one included when the
  // limit is low enough to end them soon) and a random check byte.
  task automatic send_frame();
    bit                noisy;
    bit                good_crc;
    int                pick;
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] b;
    lpr_result_t       verdict;
    bit                done;
    noisy    = ($urandom_range(0, 99) < 15);
    good_crc = !noisy && ($urandom_range(0, 99) < 80);
    pick     = $urandom_range(0, 99);
    if (noisy) begin
      hdr = (ovf_limit < 100) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(2, 255));
    end else if (pick < 90) begin
      hdr = 8'($urandom_range(2, 12));
    end else if (pick < 98) begin
      hdr = 8'($urandom_range(13, 64));
    end else begin
      hdr = 8'($urandom_range(65, 255));
    end
    done = 1'b0;
    while (!done) begin
      if (rx_count == 0) begin
        b = hdr;
      end else if (rx_count + 1'b1 == {3'b000, hdr_len} && good_crc) begin
        b = crc_acc[7:0];
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      done = frame_step(b, verdict);
      if (done) begin
        pending_verdicts.push_back(verdict);
      end
      send_byte(b);
    end
  endtask

  // Stream packets until this phase's byte budget is spent. In a mixed phase
  // the idle pattern is drawn afresh for every packet.
  task automatic run_phase(input idle_mode_t m, input int budget, input bit mixed);
    int stop_at;
    stop_at      = bytes_sent + budget;
    traffic_mode = m;
    while (bytes_sent < stop_at) begin
      if (mixed) begin
        traffic_mode = idle_mode_t'($urandom_range(0, 3));
      end
      send_frame();
    end
  endtask

  // Receiver side: random stalls per the current pattern, or a long counted
  // hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (start_holdoff) begin
      hold_left     = HOLDOFF_CYCLES;
      start_holdoff = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < snk_stall_pct(traffic_mode));
    end
  end

  // Check every verdict transaction against the oldest prediction.
  always @(posedge clk) begin
    lpr_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        verdict_errors++;
        if (verdict_errors <= MAX_REPORTS) begin
          $display("%0t: unexpected verdict status=%0d register_value=0x%02h",
                   $realtime, out_status, out_register_value);
        end
      end else begin
        want = pending_verdicts.pop_front();
        if (out_status !== want.status || out_register_value !== want.register_value) begin
          verdict_errors++;
          if (verdict_errors <= MAX_REPORTS) begin
            $display({"%0t: verdict mismatch: status exp %0d got %0d, ",
                      "register_value exp 0x%02h got 0x%02h"},
                     $realtime, want.status, out_status, want.register_value,
                     out_register_value);
          end
        end
      end
    end
  end

  // Watchdog: give up when neither side has moved a transaction for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    stim_row_t         row;
    logic [BYTE_W-1:0] b;
    lpr_result_t       verdict;
    bit                got;

    clear_frame();
    ovf_limit = LIMIT_RESET;

    // Hold reset, then release it once.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling.
    traffic_mode = IDLE_NONE;
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_LIMIT) begin
        set_limit(row.value);
      end else begin
        case (row.kind)
          ROW_GOOD_END: b = crc_acc[7:0];
          ROW_BAD_END:  b = ~crc_acc[7:0];
          default:      b = row.value[BYTE_W-1:0];
        endcase
        got = frame_step(b, verdict);
        if (row.typed) begin
          verdict.status         = row.status;
          verdict.register_value = row.regval;
          pending_verdicts.push_back(verdict);
        end else if (got) begin
          pending_verdicts.push_back(verdict);
        end
        send_byte(b);
      end
    end

    // Random phases, one idle pattern and one limit each.
    run_phase(IDLE_NONE, 300, 1'b0);
    set_limit(11'd24);
    run_phase(IDLE_SRC, 300, 1'b0);
    set_limit(LIMIT_RESET);
    run_phase(IDLE_SNK, 300, 1'b0);
    set_limit(MIN_LENGTH);
    run_phase(IDLE_BOTH, 150, 1'b0);
    set_limit(11'd300);

    // Back up the block: hold the receiver off while bytes keep coming
    // back to back, then pause the sender until every verdict is out.
    start_holdoff = 1'b1;
    run_phase(IDLE_NONE, 150, 1'b0);
    wait_drained();

    run_phase(IDLE_NONE, 650, 1'b1);

    // Drain, let any late transaction show up, then report.
    wait_drained();
    traffic_mode = IDLE_NONE;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (verdict_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
